### hdl/srms_pkg.sv
`timescale 1ns / 1ps

package srms_pkg;

   // Signal format: Q8.24 signed, saturating.
   localparam int SIG_W     = 32;
   localparam int FRAC_BITS = 24;
   localparam int LOG_W     = 40;

   // Configuration register indexes.
   localparam logic [1:0] CSR_MEAN_REV = 2'd0;
   localparam logic [1:0] CSR_VOL      = 2'd1;
   localparam logic [1:0] CSR_DT       = 2'd2;
   localparam logic [1:0] CSR_DT_ROOT  = 2'd3;

   localparam logic [30:0] DT_RESET  = 31'h0100_0000;
   localparam logic [31:0] ONE_Q30   = 32'h4000_0000;
   localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;

   // Exponential polynomial coefficients, Q2.30.
   localparam logic [31:0] EXP_C1 = 32'd744261118;
   localparam logic [31:0] EXP_C2 = 32'd257941248;
   localparam logic [31:0] EXP_C3 = 32'd59597083;
   localparam logic [31:0] EXP_C4 = 32'd10327387;
   localparam logic [31:0] EXP_C5 = 32'd1431680;

   // Selects for the three exponentials.
   localparam logic [1:0] EXP_DISC_P  = 2'd0;
   localparam logic [1:0] EXP_DISC_Q  = 2'd1;
   localparam logic [1:0] EXP_DENSITY = 2'd2;

   localparam logic [2:0] HORNER_LAST = 3'd4;

   // Datapath steps issued by the controller.
   typedef enum logic [4:0] {
      ST_NOP,
      ST_M_DW,
      ST_M_LDT,
      ST_M_SL,
      ST_M_ARP,
      ST_M_ARQ,
      ST_M_SDW,
      ST_M_LL,
      ST_M_LDW,
      ST_M_LLDT,
      ST_M_DPT,
      ST_M_DQT,
      ST_M_SDWQ,
      ST_RATES,
      ST_SUMS,
      ST_M_ARGP,
      ST_M_ARGQ,
      ST_POST_ARGQ,
      ST_E_LOG,
      ST_E_FRAC,
      ST_E_MUL,
      ST_E_ADD,
      ST_E_MANT,
      ST_E_SHIFT
   } step_type;

   typedef struct packed {
      step_type   step;
      logic [2:0] horner;
      logic [1:0] exp_sel;
      logic       load_in;
      logic       load_out;
   } cmd_type;

   // Sign extension of a signal to the working width.
   function automatic logic signed [41:0] sext42(input logic signed [31:0] v);
      return {{10{v[31]}}, v};
   endfunction

   // Saturation to the signed signal width.
   function automatic logic signed [31:0] sat_sig(input logic signed [41:0] v);
      logic signed [41:0] hi;
      logic signed [41:0] lo;
      hi = 42'sh0007FFFFFFF;
      lo = -42'sh00080000000;
      if (v > hi) begin
         return 32'sh7FFF_FFFF;
      end else if (v < lo) begin
         return 32'sh8000_0000;
      end
      return v[31:0];
   endfunction

   // Horner coefficients after the leading one, highest order first.
   function automatic logic [31:0] horner_coef(input logic [2:0] h);
      case (h)
         3'd0:    return EXP_C4;
         3'd1:    return EXP_C3;
         3'd2:    return EXP_C2;
         3'd3:    return EXP_C1;
         default: return ONE_Q30;
      endcase
   endfunction

endpackage

### hdl/short_rate_measure_switch_step.sv
`timescale 1ns / 1ps
// Short-rate Euler step under the real-world and risk-neutral measures.
// The input channel (req_) carries one path step per item; req_tuser marks
// the first step of a path, which reloads both rates from the item's start
// rate and resets the discounts and the log density before the step is taken.
// The result channel (rsp_) returns one item per input item: both new rates,
// both discount factors and the density.
// Configuration registers are written through csr_; the user must do so only
// while the block is idle, which the block itself does not enforce. All
// arithmetic goes through one shared 33 by 33 bit multiplier, driven by a
// step sequencer: the steps of the rate and log density update, then the
// steps of each of the three exponentials (argument scaling, a Horner
// polynomial of five multiply and add step pairs, mantissa product and
// shift). The next item is accepted only once the last result is loaded,
// so a new item is never taken while one is still in the sequence.
// A result waits in the output register while rsp_tready is low; the next
// item is accepted and worked on meanwhile, but is held before its result
// load until the waiting one is taken.
// Reset clears the path state to rate zero, unit discounts and zero log density,
// and the registers to zero, except the step size and its root, which are one.

module short_rate_measure_switch_step import srms_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [127:0]  req_tdata,  // start_rate, theta, market_price_of_risk, normal_shock
   input  logic          req_tuser,  // first_step
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [159:0]  rsp_tdata,  // rate_p, rate_q, disc_p, disc_q, density
   input  logic          csr_wen,
   input  logic [1:0]    csr_addr,
   input  logic [31:0]   csr_wdata
);

   cmd_type            cmd;
   logic signed [31:0] rate_p, rate_q;
   logic [31:0]        disc_p, disc_q, density;

   srms_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   srms_dp u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .csr_wen              (csr_wen),
      .csr_addr             (csr_addr),
      .csr_wdata            (csr_wdata),
      .first_step           (req_tuser),
      .start_rate           (req_tdata[31:0]),
      .theta                (req_tdata[63:32]),
      .market_price_of_risk (req_tdata[95:64]),
      .normal_shock         (req_tdata[127:96]),
      .rate_p               (rate_p),
      .rate_q               (rate_q),
      .disc_p               (disc_p),
      .disc_q               (disc_q),
      .density              (density)
   );

   assign rsp_tdata = {density, disc_q, disc_p, rate_q, rate_p};

endmodule

### hdl/srms_ctrl.sv
`timescale 1ns / 1ps

module srms_ctrl import srms_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   output logic    rsp_tvalid,
   input  logic    rsp_tready,
   output cmd_type cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_RUN,
      S_DONE
   } state_type;

   state_type  state_ff;
   step_type   step_ff;
   logic [2:0] horner_ff;
   logic [1:0] exp_ff;
   logic       rsp_valid_ff;
   logic       accept;
   logic       out_free;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // Commands to the datapath.
   always_comb begin
      cmd.step     = (state_ff == S_RUN) ? step_ff : ST_NOP;
      cmd.horner   = horner_ff;
      cmd.exp_sel  = exp_ff;
      cmd.load_in  = accept;
      cmd.load_out = (state_ff == S_DONE) && out_free;
   end

   // Sequencer and output valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= ST_NOP;
         horner_ff    <= '0;
         exp_ff       <= EXP_DISC_P;
         rsp_valid_ff <= 1'b0;
      end else begin
         if ((state_ff == S_DONE) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  state_ff  <= S_RUN;
                  step_ff   <= ST_M_DW;
                  horner_ff <= '0;
                  exp_ff    <= EXP_DISC_P;
               end
            end
            S_RUN: begin
               case (step_ff)
                  ST_M_DW:      step_ff <= ST_M_LDT;
                  ST_M_LDT:     step_ff <= ST_M_SL;
                  ST_M_SL:      step_ff <= ST_M_ARP;
                  ST_M_ARP:     step_ff <= ST_M_ARQ;
                  ST_M_ARQ:     step_ff <= ST_M_SDW;
                  ST_M_SDW:     step_ff <= ST_M_LL;
                  ST_M_LL:      step_ff <= ST_M_LDW;
                  ST_M_LDW:     step_ff <= ST_M_LLDT;
                  ST_M_LLDT:    step_ff <= ST_M_DPT;
                  ST_M_DPT:     step_ff <= ST_M_DQT;
                  ST_M_DQT:     step_ff <= ST_M_SDWQ;
                  ST_M_SDWQ:    step_ff <= ST_RATES;
                  ST_RATES:     step_ff <= ST_SUMS;
                  ST_SUMS:      step_ff <= ST_M_ARGP;
                  ST_M_ARGP:    step_ff <= ST_M_ARGQ;
                  ST_M_ARGQ:    step_ff <= ST_POST_ARGQ;
                  ST_POST_ARGQ: step_ff <= ST_E_LOG;
                  ST_E_LOG:     step_ff <= ST_E_FRAC;
                  ST_E_FRAC: begin
                     step_ff   <= ST_E_MUL;
                     horner_ff <= '0;
                  end
                  ST_E_MUL:     step_ff <= ST_E_ADD;
                  ST_E_ADD: begin
                     if (horner_ff == HORNER_LAST) begin
                        step_ff <= ST_E_MANT;
                     end else begin
                        step_ff   <= ST_E_MUL;
                        horner_ff <= horner_ff + 3'd1;
                     end
                  end
                  ST_E_MANT:    step_ff <= ST_E_SHIFT;
                  ST_E_SHIFT: begin
                     if (exp_ff == EXP_DENSITY) begin
                        step_ff  <= ST_NOP;
                        state_ff <= S_DONE;
                     end else begin
                        step_ff <= ST_E_LOG;
                        exp_ff  <= exp_ff + 2'd1;
                     end
                  end
                  default:      step_ff <= ST_NOP;
               endcase
            end
            S_DONE: begin
               if (out_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // An accepted item always starts the sequence at its first multiply.
   a_start: assert property (@(posedge clock) disable iff (reset)
      accept |=> (cmd.step == ST_M_DW))
      else $error("sequence did not start after an accepted item");

   // A new result is loaded only when the output register is free.
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid_ff || rsp_tready))
      else $error("result loaded over an untaken result");

   a_load_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> rsp_tvalid)
      else $error("loaded result not presented");

   // Only three exponentials exist.
   a_exp_range: assert property (@(posedge clock) disable iff (reset)
      exp_ff <= EXP_DENSITY)
      else $error("exponential select out of range");

endmodule

### hdl/srms_dp.sv
`timescale 1ns / 1ps

module srms_dp import srms_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   input  logic               csr_wen,
   input  logic [1:0]         csr_addr,
   input  logic [31:0]        csr_wdata,
   input  logic               first_step,
   input  logic signed [31:0] start_rate,
   input  logic signed [31:0] theta,
   input  logic signed [31:0] market_price_of_risk,
   input  logic signed [31:0] normal_shock,
   output logic signed [31:0] rate_p,
   output logic signed [31:0] rate_q,
   output logic [31:0]        disc_p,
   output logic [31:0]        disc_q,
   output logic [31:0]        density
);

   // Configuration.
   logic signed [31:0] a_ff, vol_ff;
   logic [30:0]        dt_ff, srt_ff;
   // Path state.
   logic signed [31:0] rp_ff, rq_ff;
   logic [31:0]        dp_ff, dq_ff;
   logic signed [39:0] ld_ff;
   // Item and intermediate values.
   logic signed [31:0] theta_ff, lam_ff, z_ff;
   logic signed [31:0] dw_ff, ldt_ff, sl_ff, arp_ff, arq_ff, sdw_ff, ll_ff, ldw_ff;
   logic signed [31:0] lldt_ff, drp_ff, drq_ff, dwq_ff, dpt_ff, dqt_ff;
   logic signed [31:0] np_ff, nq_ff, sp_ff, sq_ff, xp_ff, xq_ff;
   logic [31:0]        dens_ff, poly_ff;
   logic signed [11:0] k_ff;
   logic [29:0]        f30_ff;
   logic signed [65:0] prod_ff;
   // Output register.
   logic signed [31:0] rate_p_ff, rate_q_ff;
   logic [31:0]        disc_p_ff, disc_q_ff, dens_out_ff;

   logic signed [32:0] opa, opb;
   logic signed [31:0] mq;
   logic signed [31:0] x_sel;
   logic [31:0]        mant_sel;
   logic signed [41:0] lsum;
   logic signed [39:0] ld_in;
   logic signed [12:0] shift_s;
   logic signed [12:0] shift_n;
   logic [63:0]        prod_u, shr, lim;
   logic [31:0]        shl, exp_res;

   // Product scaled back to the signal format.
   assign mq = sat_sig(prod_ff[65:24]);

   // Exponent argument and mantissa of the current exponential.
   always_comb begin
      case (cmd.exp_sel)
         EXP_DISC_P: begin
            x_sel    = xp_ff;
            mant_sel = dp_ff;
         end
         EXP_DISC_Q: begin
            x_sel    = xq_ff;
            mant_sel = dq_ff;
         end
         default: begin
            if (ld_ff > 40'sh007FFFFFFF) begin
               x_sel = 32'sh7FFF_FFFF;
            end else if (ld_ff < -40'sh0080000000) begin
               x_sel = 32'sh8000_0000;
            end else begin
               x_sel = ld_ff[31:0];
            end
            mant_sel = 32'd1;
         end
      endcase
   end

   // Operand selection for the shared multiplier.
   always_comb begin
      opa = '0;
      opb = '0;
      case (cmd.step)
         ST_M_DW:   begin opa = {2'b00, srt_ff};       opb = {z_ff[31], z_ff};     end
         ST_M_LDT:  begin opa = {lam_ff[31], lam_ff};  opb = {2'b00, dt_ff};       end
         ST_M_SL:   begin opa = {vol_ff[31], vol_ff};  opb = {lam_ff[31], lam_ff}; end
         ST_M_ARP:  begin opa = {a_ff[31], a_ff};      opb = {rp_ff[31], rp_ff};   end
         ST_M_ARQ:  begin opa = {a_ff[31], a_ff};      opb = {rq_ff[31], rq_ff};   end
         ST_M_SDW:  begin opa = {vol_ff[31], vol_ff};  opb = {dw_ff[31], dw_ff};   end
         ST_M_LL:   begin opa = {lam_ff[31], lam_ff};  opb = {lam_ff[31], lam_ff}; end
         ST_M_LDW:  begin opa = {lam_ff[31], lam_ff};  opb = {dw_ff[31], dw_ff};   end
         ST_M_LLDT: begin opa = {ll_ff[31], ll_ff};    opb = {2'b00, dt_ff};       end
         ST_M_DPT:  begin opa = {drp_ff[31], drp_ff};  opb = {2'b00, dt_ff};       end
         ST_M_DQT:  begin opa = {drq_ff[31], drq_ff};  opb = {2'b00, dt_ff};       end
         ST_M_SDWQ: begin opa = {vol_ff[31], vol_ff};  opb = {dwq_ff[31], dwq_ff}; end
         ST_M_ARGP: begin opa = {sp_ff[31], sp_ff};    opb = {2'b00, dt_ff};       end
         ST_M_ARGQ: begin opa = {sq_ff[31], sq_ff};    opb = {2'b00, dt_ff};       end
         ST_E_LOG:  begin opa = {x_sel[31], x_sel};    opb = {2'b00, LOG2E_Q30};   end
         ST_E_MUL:  begin opa = {1'b0, poly_ff};       opb = {3'b000, f30_ff};     end
         ST_E_MANT: begin opa = {1'b0, mant_sel};      opb = {1'b0, poly_ff};      end
         default:   begin opa = '0;                    opb = '0;                   end
      endcase
   end

   // Log density update, saturated to its own width.
   always_comb begin
      lsum = {{2{ld_ff[39]}}, ld_ff} - sext42(ldw_ff) - sext42(lldt_ff >>> 1);
      if (lsum > 42'sh007FFFFFFFFF) begin
         ld_in = 40'sh7F_FFFF_FFFF;
      end else if (lsum < -42'sh008000000000) begin
         ld_in = 40'sh80_0000_0000;
      end else begin
         ld_in = lsum[39:0];
      end
   end

   // Final scaling of mantissa times polynomial by two to the power k.
   always_comb begin
      shift_s = ((cmd.exp_sel == EXP_DENSITY) ? 13'sd14 : 13'sd30) - {k_ff[11], k_ff};
      shift_n = -shift_s;
      prod_u  = prod_ff[63:0];
      shr     = prod_u >> shift_s[5:0];
      lim     = {32'd0, 32'hFFFF_FFFF >> shift_n[4:0]};
      shl     = prod_u[31:0] << shift_n[4:0];
      if (shift_s >= 13'sd64) begin
         exp_res = '0;
      end else if (shift_s >= 13'sd0) begin
         exp_res = (shr[63:32] != 32'd0) ? 32'hFFFF_FFFF : shr[31:0];
      end else if (prod_u == 64'd0) begin
         exp_res = '0;
      end else if (shift_n >= 13'sd32 || prod_u > lim) begin
         exp_res = 32'hFFFF_FFFF;
      end else begin
         exp_res = shl;
      end
   end

   // Configuration and path state.
   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff   <= '0;
         vol_ff <= '0;
         dt_ff  <= DT_RESET;
         srt_ff <= DT_RESET;
         rp_ff  <= '0;
         rq_ff  <= '0;
         dp_ff  <= ONE_Q30;
         dq_ff  <= ONE_Q30;
         ld_ff  <= '0;
      end else begin
         if (csr_wen) begin
            case (csr_addr)
               CSR_MEAN_REV: a_ff   <= csr_wdata;
               CSR_VOL:      vol_ff <= csr_wdata;
               CSR_DT:       dt_ff  <= csr_wdata[30:0];
               CSR_DT_ROOT:  srt_ff <= csr_wdata[30:0];
               default:      ;
            endcase
         end
         if (cmd.load_in && first_step) begin
            rp_ff <= start_rate;
            rq_ff <= start_rate;
            dp_ff <= ONE_Q30;
            dq_ff <= ONE_Q30;
            ld_ff <= '0;
         end
         case (cmd.step)
            ST_RATES: ld_ff <= ld_in;
            ST_SUMS: begin
               rp_ff <= np_ff;
               rq_ff <= nq_ff;
            end
            ST_E_SHIFT: begin
               if (cmd.exp_sel == EXP_DISC_P) begin
                  dp_ff <= exp_res;
               end else if (cmd.exp_sel == EXP_DISC_Q) begin
                  dq_ff <= exp_res;
               end
            end
            default: ;
         endcase
      end
   end

   // Multiplier, intermediate values and output register.
   always_ff @(posedge clock) begin
      prod_ff <= opa * opb;
      if (cmd.load_in) begin
         theta_ff <= theta;
         lam_ff   <= market_price_of_risk;
         z_ff     <= normal_shock;
      end
      case (cmd.step)
         ST_M_LDT:  dw_ff  <= mq;
         ST_M_SL:   ldt_ff <= mq;
         ST_M_ARP:  sl_ff  <= mq;
         ST_M_ARQ:  arp_ff <= mq;
         ST_M_SDW:  arq_ff <= mq;
         ST_M_LL:   sdw_ff <= mq;
         ST_M_LDW:  ll_ff  <= mq;
         ST_M_LLDT: begin
            ldw_ff <= mq;
            drp_ff <= sat_sig(sext42(theta_ff) - sext42(arp_ff) + sext42(sl_ff));
            drq_ff <= sat_sig(sext42(theta_ff) - sext42(arq_ff));
            dwq_ff <= sat_sig(sext42(dw_ff) + sext42(ldt_ff));
         end
         ST_M_DPT:  lldt_ff <= mq;
         ST_M_DQT:  dpt_ff  <= mq;
         ST_M_SDWQ: dqt_ff  <= mq;
         ST_RATES: begin
            np_ff <= sat_sig(sext42(rp_ff) + sext42(dpt_ff) + sext42(sdw_ff));
            nq_ff <= sat_sig(sext42(rq_ff) + sext42(dqt_ff) + sext42(mq));
         end
         ST_SUMS: begin
            sp_ff <= sat_sig(sext42(rp_ff) + sext42(np_ff));
            sq_ff <= sat_sig(sext42(rq_ff) + sext42(nq_ff));
         end
         ST_M_ARGQ:    xp_ff <= -(mq >>> 1);
         ST_POST_ARGQ: xq_ff <= -(mq >>> 1);
         ST_E_FRAC: begin
            k_ff    <= prod_ff[65:54];
            f30_ff  <= {prod_ff[53:30], 6'b000000};
            poly_ff <= EXP_C5;
         end
         ST_E_ADD:  poly_ff <= horner_coef(cmd.horner) + prod_ff[61:30];
         ST_E_SHIFT: begin
            if (cmd.exp_sel == EXP_DENSITY) begin
               dens_ff <= exp_res;
            end
         end
         default: ;
      endcase
      if (cmd.load_out) begin
         rate_p_ff   <= rp_ff;
         rate_q_ff   <= rq_ff;
         disc_p_ff   <= dp_ff;
         disc_q_ff   <= dq_ff;
         dens_out_ff <= dens_ff;
      end
   end

   assign rate_p  = rate_p_ff;
   assign rate_q  = rate_q_ff;
   assign disc_p  = disc_p_ff;
   assign disc_q  = disc_q_ff;
   assign density = dens_out_ff;

endmodule
